// ===== rtl/tsoc_pkg.sv =====
// ----------------------------------------------------------------------------
// tsoc_pkg
// Shared widths, codes and controller/datapath command and status types for
// the tensor stride-order and contiguity unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tsoc_pkg;

  // Default number of stored dimensions
  localparam int unsigned MAX_DIMS_DEF = 8;

  // Field widths
  localparam int unsigned SIZE_W   = 47;
  localparam int unsigned STRIDE_W = 48;
  localparam int unsigned POS_W    = 3;
  localparam int unsigned CONTIG_W = 2;
  localparam int unsigned ORDER_W  = 3;

  // Multi-cycle multiplier: two halves per operand, four partial products
  localparam int unsigned HALF_W    = 24;
  localparam int unsigned MUL_W     = 2 * HALF_W;
  localparam int unsigned PROD_W    = 2 * MUL_W;
  localparam int unsigned MUL_STEPS = 4;

  // Contiguity codes
  typedef enum logic [CONTIG_W-1:0] {
    CONTIG_FALSE = 2'd0,
    CONTIG_TRUE  = 2'd1,
    CONTIG_NONE  = 2'd2
  } contig_e;

  // Controller to datapath commands
  typedef struct packed {
    logic clr;        // end of run: drop per-dimension flags
    logic load;       // store the incoming dimension
    logic sort_ld_a;  // latch pivot stride for rank counting
    logic sort_cmp;   // compare one stored stride against the pivot
    logic cont_eval;  // evaluate contiguity of one position
    logic mul_start;  // start stride * size of the entry at the position
    logic emit;       // load one result into the output register
    logic emit_err;   // load the error result
    logic last_res;   // marks the final result of the run
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic sel_nz;      // dimension at idx has nonzero stride
    logic arr_live;    // rearranged entry at idx is not broadcast
    logic mul_done;    // product available this cycle
    logic out_free;    // output register can take a result
    logic stride_neg;  // incoming stride is negative
  } stat_t;

endpackage

// ===== rtl/tsoc_if.sv =====
// ----------------------------------------------------------------------------
// tsoc_if
// Valid/ready channel interfaces: dimension input and result output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface tsoc_dim_if;
  import tsoc_pkg::*;

  logic                       valid;
  logic                       ready;
  logic        [SIZE_W-1:0]   dim_size;
  logic signed [STRIDE_W-1:0] dim_stride;
  logic                       last_dim;

  modport source (output valid, dim_size, dim_stride, last_dim, input ready);
  modport sink   (input valid, dim_size, dim_stride, last_dim, output ready);
endinterface

interface tsoc_res_if;
  import tsoc_pkg::*;

  logic                valid;
  logic                ready;
  logic [POS_W-1:0]    position;
  logic [CONTIG_W-1:0] contiguity;
  logic [ORDER_W-1:0]  order_of_dim;
  logic                error;
  logic                final_res;

  modport source (output valid, position, contiguity, order_of_dim, error, final_res,
                  input ready);
  modport sink   (input valid, position, contiguity, order_of_dim, error, final_res,
                  output ready);
endinterface

// ===== rtl/tsoc_dpath.sv =====
// ----------------------------------------------------------------------------
// tsoc_dpath
// Dimension store, rank counter, rearrangement lookup, iterative multiplier
// for contiguity products, and the result output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tsoc_dpath #(
  parameter  int unsigned MAX_DIMS = tsoc_pkg::MAX_DIMS_DEF,
  localparam int unsigned IDX_W    = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1,
  localparam int unsigned CNT_W    = $clog2(MAX_DIMS + 1)
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  tsoc_pkg::cmd_t                  cmd_i,
  input  logic [IDX_W-1:0]                idx_i,
  input  logic [CNT_W-1:0]                count_i,
  output tsoc_pkg::stat_t                 stat_o,
  input  logic [tsoc_pkg::SIZE_W-1:0]     dim_size_i,
  input  logic [tsoc_pkg::STRIDE_W-1:0]   dim_stride_i,
  input  logic                            res_ready_i,
  output logic                            res_valid_o,
  output logic [tsoc_pkg::POS_W-1:0]      position_o,
  output logic [tsoc_pkg::CONTIG_W-1:0]   contiguity_o,
  output logic [tsoc_pkg::ORDER_W-1:0]    order_of_dim_o,
  output logic                            error_o,
  output logic                            final_res_o
);
  import tsoc_pkg::*;

  // Dimension store and per-dimension flags
  logic [SIZE_W-1:0]   size_q   [MAX_DIMS];
  logic [STRIDE_W-1:0] stride_q [MAX_DIMS];
  logic [MAX_DIMS-1:0] nz_q;
  logic [MAX_DIMS-1:0] bc_q;
  logic [IDX_W-1:0]    sidx_q   [MAX_DIMS];
  contig_e             contig_q [MAX_DIMS];

  // Rearrangement lookup
  logic [IDX_W-1:0]    pc       [MAX_DIMS];
  logic [IDX_W-1:0]    arr_sel;
  logic [IDX_W-1:0]    rank_sel;
  logic [IDX_W-1:0]    rd_idx;
  logic [STRIDE_W-1:0] rd_stride;
  logic [SIZE_W-1:0]   rd_size;

  // Rank counting
  logic [STRIDE_W-1:0] a_q;
  logic [IDX_W-1:0]    a_idx_q;
  logic [IDX_W-1:0]    scnt_q;
  logic [IDX_W-1:0]    scnt_d;
  logic                hit;

  // Multiplier and next-entry product
  logic                mbusy_q;
  logic [2:0]          mstep_q;
  logic [MUL_W-1:0]    ma_q;
  logic [MUL_W-1:0]    mb_q;
  logic [MUL_W-1:0]    pp_q;
  logic [1:0]          psh_q;
  logic [PROD_W-1:0]   acc_q;
  logic [PROD_W-1:0]   acc_d;
  logic [PROD_W-1:0]   pp_shift;
  logic [HALF_W-1:0]   a_part;
  logic [HALF_W-1:0]   b_part;
  logic                mul_done;
  logic                has_next_q;
  logic [PROD_W-1:0]   nprod_q;
  contig_e             contig_new;

  // Output register
  logic                res_valid_q;
  logic [POS_W-1:0]    position_q;
  contig_e             contiguity_q;
  logic [ORDER_W-1:0]  order_q;
  logic                error_q;
  logic                final_q;
  logic [CNT_W-1:0]    order_full;
  logic                out_free;

  // Stored dimensions (undefined until written)
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      size_q[idx_i]   <= dim_size_i;
      stride_q[idx_i] <= dim_stride_i;
    end
  end

  // Nonzero-stride and broadcast flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nz_q <= '0;
      bc_q <= '0;
    end else if (cmd_i.clr) begin
      nz_q <= '0;
      bc_q <= '0;
    end else if (cmd_i.load) begin
      nz_q[idx_i] <= |dim_stride_i;
      bc_q[idx_i] <= ~|dim_stride_i || (dim_size_i == SIZE_W'(1));
    end
  end

  // Count of nonzero-stride positions left of each position
  always_comb begin
    for (int p = 0; p < MAX_DIMS; p++) begin
      pc[p] = '0;
      for (int q = 0; q < MAX_DIMS; q++) begin
        if (q < p && nz_q[q]) pc[p] = pc[p] + IDX_W'(1);
      end
    end
  end

  // Dimension placed at position idx, and position taken by dimension idx
  always_comb begin
    arr_sel  = idx_i;
    rank_sel = idx_i;
    if (nz_q[idx_i]) begin
      for (int d = 0; d < MAX_DIMS; d++) begin
        if (nz_q[d] && sidx_q[d] == pc[idx_i]) arr_sel = IDX_W'(d);
        if (nz_q[d] && pc[d] == sidx_q[idx_i]) rank_sel = IDX_W'(d);
      end
    end
  end

  // Single read port
  assign rd_idx    = (cmd_i.cont_eval || cmd_i.mul_start) ? arr_sel : idx_i;
  assign rd_stride = stride_q[rd_idx];
  assign rd_size   = size_q[rd_idx];

  // Stable descending rank: larger strides, or equal strides earlier
  assign hit = nz_q[idx_i] &&
               ((rd_stride > a_q) || (rd_stride == a_q && idx_i < a_idx_q));
  assign scnt_d = scnt_q + IDX_W'(hit);

  always_ff @(posedge clk_i) begin
    if (cmd_i.sort_ld_a) begin
      a_q     <= rd_stride;
      a_idx_q <= idx_i;
      scnt_q  <= '0;
    end else if (cmd_i.sort_cmp) begin
      scnt_q          <= scnt_d;
      sidx_q[a_idx_q] <= scnt_d;
    end
  end

  // Contiguity of the entry at a position against the next live entry
  always_comb begin
    if (bc_q[arr_sel]) begin
      contig_new = CONTIG_NONE;
    end else if (has_next_q) begin
      contig_new = (nprod_q == PROD_W'(rd_stride)) ? CONTIG_TRUE : CONTIG_FALSE;
    end else begin
      contig_new = (rd_stride == STRIDE_W'(1)) ? CONTIG_TRUE : CONTIG_FALSE;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cont_eval) contig_q[idx_i] <= contig_new;
  end

  // Multiplier: one 24x24 partial product per cycle, accumulated in the next cycle
  assign a_part   = mstep_q[0] ? ma_q[MUL_W-1:HALF_W] : ma_q[HALF_W-1:0];
  assign b_part   = mstep_q[1] ? mb_q[MUL_W-1:HALF_W] : mb_q[HALF_W-1:0];
  assign mul_done = mbusy_q && (mstep_q == 3'(MUL_STEPS));

  always_comb begin
    case (psh_q)
      2'd0:    pp_shift = PROD_W'(pp_q);
      2'd1:    pp_shift = PROD_W'(pp_q) << HALF_W;
      2'd2:    pp_shift = PROD_W'(pp_q) << (2 * HALF_W);
      default: pp_shift = '0;
    endcase
  end

  assign acc_d = acc_q + pp_shift;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mbusy_q    <= 1'b0;
      mstep_q    <= '0;
      has_next_q <= 1'b0;
    end else begin
      if (cmd_i.clr) has_next_q <= 1'b0;
      if (cmd_i.mul_start) begin
        mbusy_q <= 1'b1;
        mstep_q <= '0;
      end else if (mbusy_q) begin
        mstep_q <= mstep_q + 3'd1;
        if (mul_done) begin
          mbusy_q    <= 1'b0;
          has_next_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_start) begin
      ma_q  <= MUL_W'(rd_stride);
      mb_q  <= MUL_W'(rd_size);
      acc_q <= '0;
    end else if (mbusy_q) begin
      if (mstep_q < 3'(MUL_STEPS)) begin
        pp_q  <= a_part * b_part;
        psh_q <= 2'({1'b0, mstep_q[0]} + {1'b0, mstep_q[1]});
      end
      if (mstep_q != 3'd0) acc_q <= acc_d;
      if (mul_done) nprod_q <= acc_d;
    end
  end

  // Output register
  assign out_free   = !res_valid_q || res_ready_i;
  assign order_full = count_i - CNT_W'(1) - CNT_W'(rank_sel);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (cmd_i.emit || cmd_i.emit_err) begin
      res_valid_q <= 1'b1;
    end else if (res_ready_i) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      position_q   <= POS_W'(idx_i);
      contiguity_q <= contig_q[idx_i];
      order_q      <= ORDER_W'(order_full);
      error_q      <= 1'b0;
      final_q      <= cmd_i.last_res;
    end else if (cmd_i.emit_err) begin
      position_q   <= '0;
      contiguity_q <= CONTIG_FALSE;
      order_q      <= '0;
      error_q      <= 1'b1;
      final_q      <= 1'b1;
    end
  end

  assign res_valid_o    = res_valid_q;
  assign position_o     = position_q;
  assign contiguity_o   = contiguity_q;
  assign order_of_dim_o = order_q;
  assign error_o        = error_q;
  assign final_res_o    = final_q;

  // Status
  assign stat_o.sel_nz     = nz_q[idx_i];
  assign stat_o.arr_live   = !bc_q[arr_sel];
  assign stat_o.mul_done   = mul_done;
  assign stat_o.out_free   = out_free;
  assign stat_o.stride_neg = dim_stride_i[STRIDE_W-1];

  // Checks
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit || cmd_i.emit_err) |-> out_free)
    else $error("result loaded while output register holds an untaken transaction");

  a_eval_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.cont_eval |-> !mbusy_q)
    else $error("contiguity evaluated while product still in progress");

  a_next_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |=> (has_next_q && !mbusy_q))
    else $error("finished product not recorded as next entry");

endmodule

// ===== rtl/tsoc_ctrl.sv =====
// ----------------------------------------------------------------------------
// tsoc_ctrl
// Run controller: loads dimensions, sequences rank counting, the right-to-left
// contiguity pass and result emission.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tsoc_ctrl #(
  parameter  int unsigned MAX_DIMS = tsoc_pkg::MAX_DIMS_DEF,
  localparam int unsigned IDX_W    = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1,
  localparam int unsigned CNT_W    = $clog2(MAX_DIMS + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             last_dim_i,
  input  tsoc_pkg::stat_t  stat_i,
  output tsoc_pkg::cmd_t   cmd_o,
  output logic [IDX_W-1:0] idx_o,
  output logic [CNT_W-1:0] count_o
);
  import tsoc_pkg::*;

  typedef enum logic [6:0] {
    S_LOAD   = 7'b0000001,
    S_SORT_A = 7'b0000010,
    S_SORT_J = 7'b0000100,
    S_CONT   = 7'b0001000,
    S_MUL    = 7'b0010000,
    S_EMIT   = 7'b0100000,
    S_ERR    = 7'b1000000
  } state_e;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             bad_q, bad_d;
  logic [IDX_W-1:0] i_q, i_d;
  logic [IDX_W-1:0] j_q, j_d;
  logic [IDX_W-1:0] p_q, p_d;
  logic [CNT_W-1:0] n_last;
  logic             i_last;
  logic             j_last;
  logic             p_last;

  assign n_last  = cnt_q - CNT_W'(1);
  assign i_last  = (CNT_W'(i_q) == n_last);
  assign j_last  = (CNT_W'(j_q) == n_last);
  assign p_last  = (CNT_W'(p_q) == n_last);
  assign count_o = cnt_q;

  // Next state and commands
  always_comb begin
    logic             full;
    logic [CNT_W-1:0] cnt_nx;
    logic             bad_nx;

    state_d    = state_q;
    cnt_d      = cnt_q;
    bad_d      = bad_q;
    i_d        = i_q;
    j_d        = j_q;
    p_d        = p_q;
    cmd_o      = '0;
    idx_o      = i_q;
    in_ready_o = 1'b0;
    full       = (cnt_q == CNT_W'(MAX_DIMS));
    cnt_nx     = cnt_q;
    bad_nx     = bad_q;

    case (state_q)
      S_LOAD: begin
        in_ready_o = 1'b1;
        idx_o      = IDX_W'(cnt_q);
        if (in_valid_i) begin
          // a full store drops the dimension unchecked
          if (!full) begin
            cmd_o.load = 1'b1;
            cnt_nx     = cnt_q + CNT_W'(1);
            bad_nx     = bad_q || stat_i.stride_neg;
          end
          cnt_d = cnt_nx;
          bad_d = bad_nx;
          if (last_dim_i) begin
            i_d = '0;
            if (bad_nx || cnt_nx == '0) state_d = S_ERR;
            else                        state_d = S_SORT_A;
          end
        end
      end

      S_SORT_A: begin
        idx_o = i_q;
        if (stat_i.sel_nz) begin
          cmd_o.sort_ld_a = 1'b1;
          j_d             = '0;
          state_d         = S_SORT_J;
        end else if (i_last) begin
          p_d     = IDX_W'(n_last);
          state_d = S_CONT;
        end else begin
          i_d = i_q + IDX_W'(1);
        end
      end

      S_SORT_J: begin
        idx_o          = j_q;
        cmd_o.sort_cmp = 1'b1;
        if (!j_last) begin
          j_d = j_q + IDX_W'(1);
        end else if (i_last) begin
          p_d     = IDX_W'(n_last);
          state_d = S_CONT;
        end else begin
          i_d     = i_q + IDX_W'(1);
          state_d = S_SORT_A;
        end
      end

      // right to left; product only needed when an entry is left of this one
      S_CONT: begin
        idx_o           = p_q;
        cmd_o.cont_eval = 1'b1;
        if (stat_i.arr_live && p_q != '0) begin
          cmd_o.mul_start = 1'b1;
          state_d         = S_MUL;
        end else if (p_q == '0) begin
          state_d = S_EMIT;
        end else begin
          p_d = p_q - IDX_W'(1);
        end
      end

      S_MUL: begin
        idx_o = p_q;
        if (stat_i.mul_done) begin
          p_d     = p_q - IDX_W'(1);
          state_d = S_CONT;
        end
      end

      S_EMIT: begin
        idx_o = p_q;
        if (stat_i.out_free) begin
          cmd_o.emit     = 1'b1;
          cmd_o.last_res = p_last;
          if (p_last) begin
            cmd_o.clr = 1'b1;
            cnt_d     = '0;
            bad_d     = 1'b0;
            state_d   = S_LOAD;
          end else begin
            p_d = p_q + IDX_W'(1);
          end
        end
      end

      S_ERR: begin
        if (stat_i.out_free) begin
          cmd_o.emit_err = 1'b1;
          cmd_o.clr      = 1'b1;
          cnt_d          = '0;
          bad_d          = 1'b0;
          state_d        = S_LOAD;
        end
      end

      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      cnt_q   <= '0;
      bad_q   <= 1'b0;
      i_q     <= '0;
      j_q     <= '0;
      p_q     <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      bad_q   <= bad_d;
      i_q     <= i_d;
      j_q     <= j_d;
      p_q     <= p_d;
    end
  end

  // Checks
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_DIMS))
    else $error("dimension count beyond store depth");

  a_mul_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MUL) |-> (p_q != '0))
    else $error("product computed for leftmost position");

  a_err_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ERR && stat_i.out_free) |=> (state_q == S_LOAD && cnt_q == '0 && !bad_q))
    else $error("error transaction did not end the run");

endmodule

// ===== rtl/tensor_stride_order_contiguity_unit.sv =====
// ----------------------------------------------------------------------------
// tensor_stride_order_contiguity_unit
// Dimensions are taken back to back; after the final dimension, rank counting
//   compares each nonzero-stride dimension against every stored one, the
//   contiguity pass evaluates the positions right to left and runs a product on
//   the 4-step shared multiplier for each live entry right of position 0, then
//   one result per cycle is emitted while res_o is ready.
// A negative stride yields a single error result after the final dimension is taken.
// Reset (async, active low) clears count, flags and output valid; store is not.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tensor_stride_order_contiguity_unit #(
  parameter int unsigned MAX_DIMS = tsoc_pkg::MAX_DIMS_DEF
) (
  input logic       clk_i,
  input logic       rst_ni,
  tsoc_dim_if.sink  dim_i,
  tsoc_res_if.source res_o
);
  import tsoc_pkg::*;

  localparam int unsigned IDX_W = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_DIMS + 1);

  cmd_t             cmd;
  stat_t            stat;
  logic [IDX_W-1:0] idx;
  logic [CNT_W-1:0] count;

  // Run sequencing
  tsoc_ctrl #(
    .MAX_DIMS (MAX_DIMS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (dim_i.valid),
    .in_ready_o (dim_i.ready),
    .last_dim_i (dim_i.last_dim),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .idx_o      (idx),
    .count_o    (count)
  );

  // Storage, arithmetic and result register
  tsoc_dpath #(
    .MAX_DIMS (MAX_DIMS)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .idx_i          (idx),
    .count_i        (count),
    .stat_o         (stat),
    .dim_size_i     (dim_i.dim_size),
    .dim_stride_i   (dim_i.dim_stride),
    .res_ready_i    (res_o.ready),
    .res_valid_o    (res_o.valid),
    .position_o     (res_o.position),
    .contiguity_o   (res_o.contiguity),
    .order_of_dim_o (res_o.order_of_dim),
    .error_o        (res_o.error),
    .final_res_o    (res_o.final_res)
  );

endmodule

// ===== tb/tensor_stride_order_contiguity_unit_tb.sv =====
// ----------------------------------------------------------------------------
// tensor_stride_order_contiguity_unit_tb
// Self-checking testbench. Dimensions are driven over the valid/ready input
// channel, and a scoreboard class predicts the stride order and contiguity
// results of every tensor. Each result transaction is checked field by field
// against the oldest prediction. A directed pass covers the corner cases and
// is followed by random tensors under varying source and sink idling.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tensor_stride_order_contiguity_unit_tb;
  import tsoc_pkg::*;

  localparam int unsigned NDIM        = MAX_DIMS_DEF;
  localparam int          RAND_ITEMS  = 186;
  localparam int          HOLD_CYCLES = 300;
  localparam int          DRAIN_LIMIT = 200000;
  localparam int          TAIL_CYCLES = 200;

  // One result transaction
  typedef struct packed {
    logic [POS_W-1:0]    position;
    logic [CONTIG_W-1:0] contiguity;
    logic [ORDER_W-1:0]  order_of_dim;
    logic                error;
    logic                final_res;
  } dim_result_t;

  // --------------------------------------------------------------------------
  // Scoreboard: tracks stored dimensions and queues predicted results
  // --------------------------------------------------------------------------
  class stride_order_scoreboard;
    logic [SIZE_W-1:0]   size_mem[NDIM];
    logic [STRIDE_W-1:0] stride_mem[NDIM];
    int                  n_stored;
    bit                  neg_seen;
    dim_result_t         expected_q[$];
    int                  mismatches;

    function new();
      n_stored   = 0;
      neg_seen   = 1'b0;
      mismatches = 0;
    endfunction

    function bit is_bcast(int d);
      return stride_mem[d] == '0 || size_mem[d] == 1;
    endfunction

    // Append one predicted result
    function void queue_result(dim_result_t r);
      expected_q = {expected_q, r};
    endfunction

    // Called for every accepted dimension transaction
    function void note_dim(logic [SIZE_W-1:0] sz, logic [STRIDE_W-1:0] st, logic last);
      int          n, ns, j, k, d, e;
      int          sorted_idx[NDIM];
      int          placed[NDIM];
      int          slot_of[NDIM];
      bit          ok, found;
      logic [95:0] prod;
      dim_result_t r;
      // store full: item is dropped, stride not checked
      if (n_stored < NDIM) begin
        if (st[STRIDE_W-1]) neg_seen = 1'b1;
        size_mem[n_stored]   = sz;
        stride_mem[n_stored] = st;
        n_stored++;
      end
      if (!last) return;
      n        = n_stored;
      n_stored = 0;
      if (neg_seen || n == 0) begin
        neg_seen     = 1'b0;
        r            = '0;
        r.error      = 1'b1;
        r.final_res  = 1'b1;
        queue_result(r);
        return;
      end
      // stable descending sort of the nonzero-stride dims
      ns = 0;
      for (int i = 0; i < n; i++) begin
        if (stride_mem[i] != '0) begin
          j = ns;
          while (j > 0 && stride_mem[sorted_idx[j-1]] < stride_mem[i]) begin
            sorted_idx[j] = sorted_idx[j-1];
            j--;
          end
          sorted_idx[j] = i;
          ns++;
        end
      end
      // zero-stride dims stay put, the rest fill the gaps
      k = 0;
      for (int i = 0; i < n; i++) begin
        if (stride_mem[i] == '0) begin
          placed[i] = i;
        end else begin
          placed[i] = sorted_idx[k];
          k++;
        end
      end
      for (int i = 0; i < n; i++) slot_of[placed[i]] = i;
      // contiguity against the next live entry, exact product
      for (int i = 0; i < n; i++) begin
        d = placed[i];
        r = '0;
        if (is_bcast(d)) begin
          r.contiguity = CONTIG_NONE;
        end else begin
          ok    = (stride_mem[d] == 1);
          found = 1'b0;
          for (int m = i + 1; m < n; m++) begin
            e = placed[m];
            if (!found && !is_bcast(e)) begin
              found = 1'b1;
              prod  = 96'(stride_mem[e]) * 96'(size_mem[e]);
              ok    = (prod == 96'(stride_mem[d]));
            end
          end
          r.contiguity = ok ? CONTIG_TRUE : CONTIG_FALSE;
        end
        r.position     = POS_W'(i);
        r.order_of_dim = ORDER_W'(n - 1 - slot_of[i]);
        r.final_res    = (i == n - 1);
        queue_result(r);
      end
    endfunction

    // Called for every accepted result transaction
    function void check_result(dim_result_t got);
      dim_result_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected result pos=%0d contig=%0d order=%0d err=%0b fin=%0b",
                   got.position, got.contiguity, got.order_of_dim, got.error, got.final_res);
        return;
      end
      want = expected_q.pop_front();
      if (got.position !== want.position || got.contiguity !== want.contiguity ||
          got.order_of_dim !== want.order_of_dim || got.error !== want.error ||
          got.final_res !== want.final_res) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: pos %0d/%0d contig %0d/%0d order %0d/%0d err %0b/%0b fin %0b/%0b %s",
                   want.position, got.position, want.contiguity, got.contiguity,
                   want.order_of_dim, got.order_of_dim, want.error, got.error,
                   want.final_res, got.final_res, "(expected/actual)");
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, channels and the block
  // --------------------------------------------------------------------------
  logic clk_i;
  logic rst_ni;

  tsoc_dim_if dim_if ();
  tsoc_res_if res_if ();

  tensor_stride_order_contiguity_unit u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .dim_i  (dim_if),
    .res_o  (res_if)
  );

  stride_order_scoreboard sb = new();

  int snd_idle_pct  = 0;
  int rcv_idle_pct  = 0;
  int rcv_hold_req  = 0;
  int rcv_hold_left = 0;
  int rand_sent     = 0;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Sink side: random ready, plus a long hold-off when one is requested
  initial begin
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rcv_hold_req > 0) begin
        rcv_hold_left = rcv_hold_req;
        rcv_hold_req  = 0;
      end
      if (rcv_hold_left > 0) begin
        rcv_hold_left--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= ($urandom_range(99) >= rcv_idle_pct);
      end
    end
  end

  // Result monitor
  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid === 1'b1 && res_if.ready === 1'b1)
      sb.check_result({res_if.position, res_if.contiguity, res_if.order_of_dim,
                       res_if.error, res_if.final_res});
  end

  // --------------------------------------------------------------------------
  // Stimulus tasks; all start and end at a falling edge
  // --------------------------------------------------------------------------
  task automatic send_dim(logic [SIZE_W-1:0] sz, logic [STRIDE_W-1:0] st, logic last);
    while ($urandom_range(99) < snd_idle_pct) begin
      dim_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    dim_if.valid      <= 1'b1;
    dim_if.dim_size   <= sz;
    dim_if.dim_stride <= st;
    dim_if.last_dim   <= last;
    do @(posedge clk_i); while (dim_if.ready !== 1'b1);
    sb.note_dim(sz, st, last);
    @(negedge clk_i);
  endtask

  // Hold the source off until every predicted result has come out
  task automatic wait_drained();
    dim_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic directed_dims();
    // single dim, full-width size, unit stride
    send_dim(47'h7FFF_FFFF_FFFF, 48'd1, 1'b1);
    // dense row-major 2x3x4
    send_dim(47'd2, 48'd12, 1'b0);
    send_dim(47'd3, 48'd4, 1'b0);
    send_dim(47'd4, 48'd1, 1'b1);
    // broadcast dim, size-one dim, tied strides
    send_dim(47'd5, 48'd0, 1'b0);
    send_dim(47'd1, 48'd6, 1'b0);
    send_dim(47'd7, 48'd6, 1'b0);
    send_dim(47'd3, 48'd1, 1'b1);
    // most negative stride in the middle -> error result
    send_dim(47'd4, 48'd8, 1'b0);
    send_dim(47'd2, 48'h8000_0000_0000, 1'b0);
    send_dim(47'd3, 48'd1, 1'b1);
    // overfull tensor; negative stride past the store is dropped unchecked
    for (int i = 0; i < 10; i++)
      send_dim(47'(i + 2), (i == 8) ? 48'hFFFF_FFFF_FFFF : 48'(10 - i), i == 9);
    // largest stride, zero size, product that only matches modulo 2^48
    send_dim(47'd5, 48'h7FFF_FFFF_FFFF, 1'b0);
    send_dim(47'd0, 48'h300_0000, 1'b0);
    send_dim(47'h100_0000, 48'h100_0003, 1'b1);
  endtask

  // One random tensor: mostly well-formed layouts, some wide noise
  task automatic random_tensor(output int n_items);
    logic [SIZE_W-1:0]   sz[12];
    logic [STRIDE_W-1:0] st[12];
    logic [63:0]         acc;
    int                  perm[12];
    int                  n, kind, j, tmp;
    n = ($urandom_range(99) < 8) ? $urandom_range(11, 9) : $urandom_range(8, 1);
    kind = $urandom_range(3);
    for (int i = 0; i < n; i++) perm[i] = i;
    for (int i = n - 1; i > 0; i--) begin
      j       = $urandom_range(i);
      tmp     = perm[i];
      perm[i] = perm[j];
      perm[j] = tmp;
    end
    case (kind)
      0, 1: begin
        // dense layout in a shuffled order, then perturbed
        acc = ($urandom_range(3) == 0) ? 64'($urandom_range(3, 1)) : 64'd1;
        for (int i = n - 1; i >= 0; i--) begin
          sz[perm[i]] = (kind == 0) ? SIZE_W'($urandom_range(6)) :
                                      SIZE_W'($urandom_range(4000, 1));
          st[perm[i]] = {1'b0, acc[SIZE_W-1:0]};
          acc = (acc * ((sz[perm[i]] == 0) ? 64'd1 : 64'(sz[perm[i]]))) & 64'h7FFF_FFFF_FFFF;
          if (acc == 0) acc = 64'd1;
        end
        for (int i = 0; i < n; i++) begin
          if ($urandom_range(99) < 15) st[i] = '0;
          else if ($urandom_range(99) < 10) st[i] = st[$urandom_range(n - 1)];
          if ($urandom_range(99) < 10) sz[i] = SIZE_W'(1);
        end
      end
      2: begin
        for (int i = 0; i < n; i++) begin
          sz[i] = SIZE_W'({$urandom, $urandom});
          st[i] = {1'b0, SIZE_W'({$urandom, $urandom})};
          if ($urandom_range(99) < 20) st[i] = STRIDE_W'($urandom_range(4));
        end
      end
      default: begin
        for (int i = 0; i < n; i++) begin
          sz[i] = SIZE_W'($urandom_range(4));
          st[i] = STRIDE_W'($urandom_range(8));
        end
      end
    endcase
    if ($urandom_range(99) < 10)
      st[$urandom_range(n - 1)] = {1'b1, SIZE_W'({$urandom, $urandom})};
    for (int i = 0; i < n; i++) send_dim(sz[i], st[i], i == n - 1);
    n_items = n;
  endtask

  task automatic random_phase(int budget);
    int cnt;
    int got;
    cnt = 0;
    while (cnt < budget) begin
      random_tensor(got);
      cnt += got;
    end
    rand_sent += cnt;
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int guard;
    dim_if.valid      = 1'b0;
    dim_if.dim_size   = '0;
    dim_if.dim_stride = '0;
    dim_if.last_dim   = 1'b0;
    rst_ni            = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    directed_dims();
    wait_drained();

    // source sparse, sink mostly stalled
    snd_idle_pct = 31;
    rcv_idle_pct = 80;
    random_phase(RAND_ITEMS / 3);
    wait_drained();

    // source mostly idle, sink sparse
    snd_idle_pct = 80;
    rcv_idle_pct = 31;
    random_phase(RAND_ITEMS / 3);

    // no idling; long sink hold-off first so the block backs up
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    rcv_hold_req = HOLD_CYCLES;
    random_phase(RAND_ITEMS - rand_sent);
    dim_if.valid <= 1'b0;

    guard = 0;
    while (sb.pending() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end

endmodule

// ===== tensor_stride_order_contiguity_unit.f =====
rtl/tsoc_pkg.sv
rtl/tsoc_if.sv
rtl/tsoc_dpath.sv
rtl/tsoc_ctrl.sv
rtl/tensor_stride_order_contiguity_unit.sv
tb/tensor_stride_order_contiguity_unit_tb.sv
